[src/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define CHK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/csstat_pkg.sv]
// Shared widths and engine interface types for the column statistics block.
package csstat_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 17;
  localparam int SUM_W    = 33;
  localparam int SUMSQ_W  = 47;
  localparam int STD_W    = 15;

  // Request from the accumulator side to the end-of-column engine
  typedef struct packed {
    logic                      start;
    logic [COUNT_W-1:0]        count;
    logic signed [SUM_W-1:0]   sum;
    logic [SUMSQ_W-1:0]        sumsq;
  } eng_in_t;

  // Engine status and results; results hold until the next start
  typedef struct packed {
    logic                       done;
    logic signed [SAMPLE_W-1:0] mean;
    logic [STD_W-1:0]           std_dev;
  } eng_out_t;

endpackage

[src/csstat_engine.sv]
// Bit-serial end-of-column engine: products, floor mean, variance and root.
module csstat_engine (
  input  logic               clk,
  input  logic               rst,
  input  csstat_pkg::eng_in_t  eng_in,
  output csstat_pkg::eng_out_t eng_out
);

  // Iteration counts (last step index) of each serial unit
  localparam logic [5:0] MUL_LAST  = 6'd31;  // one multiplier bit per cycle
  localparam logic [5:0] DIV_LAST  = 6'd63;  // one quotient bit per cycle
  localparam logic [5:0] SQRT_LAST = 6'd15;  // one root bit per cycle

  typedef enum logic [2:0] {
    E_IDLE, E_MUL_CS, E_MUL_S2, E_MUL_CC, E_DIV_MEAN, E_DIV_VAR, E_SQRT
  } phase_t;

  phase_t phase;
  logic [5:0] step;

  // Latched operands
  logic [csstat_pkg::COUNT_W-1:0] cnt;
  logic [31:0] mag;
  logic        neg;

  // Shift-add multiplier
  logic [63:0] mc;
  logic [31:0] mp;
  logic [63:0] prod;
  logic [63:0] prod_next;

  // Stored products
  logic [63:0] cs;
  logic [63:0] s2;
  logic [32:0] cc;
  logic [63:0] diff;

  // Restoring divider
  logic [63:0] dvd;
  logic [33:0] dsr;
  logic [33:0] rem;
  logic [63:0] quo;
  logic [33:0] rem_sh;
  logic        div_ge;
  logic [33:0] rem_next;
  logic [63:0] quo_next;

  // Restoring square root, two radicand bits per step
  logic [31:0] sv;
  logic        sat;
  logic [19:0] srem;
  logic [15:0] root;
  logic [19:0] srem_sh;
  logic [19:0] trial;
  logic        sq_ge;
  logic [19:0] srem_next;
  logic [15:0] root_next;

  // Results
  logic        done;
  logic signed [csstat_pkg::SAMPLE_W-1:0] mean;
  logic [csstat_pkg::STD_W-1:0]           std_dev;
  logic [15:0] mean_next;
  logic [32:0] neg_sum;

  // One step of each serial unit
  always_comb begin
    prod_next = prod + (mp[0] ? mc : 64'd0);

    rem_sh   = {rem[32:0], dvd[63]};
    div_ge   = (rem_sh >= dsr);
    rem_next = div_ge ? (rem_sh - dsr) : rem_sh;
    quo_next = {quo[62:0], div_ge};

    srem_sh   = {srem[17:0], sv[31:30]};
    trial     = {2'b00, root, 2'b01};
    sq_ge     = (srem_sh >= trial);
    srem_next = sq_ge ? (srem_sh - trial) : srem_sh;
    root_next = {root[14:0], sq_ge};

    diff = (cs > s2) ? (cs - s2) : 64'd0;

    // floor division: a negative sum with a remainder rounds one further down
    mean_next = neg ? (16'd0 - quo_next[15:0] - 16'(rem_next != 34'd0))
                    : quo_next[15:0];

    neg_sum = 33'd0 - eng_in.sum;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= E_IDLE;
      done  <= 1'b0;
    end else begin
      case (phase)
        E_IDLE: begin
          if (eng_in.start) begin
            done  <= 1'b0;
            cnt   <= eng_in.count;
            neg   <= eng_in.sum[csstat_pkg::SUM_W-1];
            mag   <= eng_in.sum[csstat_pkg::SUM_W-1] ? neg_sum[31:0] : eng_in.sum[31:0];
            mc    <= {17'd0, eng_in.sumsq};
            mp    <= {15'd0, eng_in.count};
            prod  <= 64'd0;
            step  <= MUL_LAST;
            phase <= E_MUL_CS;
          end
        end
        E_MUL_CS, E_MUL_S2, E_MUL_CC: begin
          prod <= prod_next;
          mc   <= {mc[62:0], 1'b0};
          mp   <= {1'b0, mp[31:1]};
          step <= step - 6'd1;
          if (step == 6'd0) begin
            prod <= 64'd0;
            step <= MUL_LAST;
            case (phase)
              E_MUL_CS: begin
                cs    <= prod_next;
                mc    <= {32'd0, mag};
                mp    <= mag;
                phase <= E_MUL_S2;
              end
              E_MUL_S2: begin
                s2    <= prod_next;
                mc    <= {47'd0, cnt};
                mp    <= {15'd0, cnt};
                phase <= E_MUL_CC;
              end
              default: begin
                cc    <= prod_next[32:0];
                dvd   <= {32'd0, mag};
                dsr   <= {17'd0, cnt};
                rem   <= 34'd0;
                quo   <= 64'd0;
                step  <= DIV_LAST;
                phase <= E_DIV_MEAN;
              end
            endcase
          end
        end
        E_DIV_MEAN, E_DIV_VAR: begin
          rem  <= rem_next;
          quo  <= quo_next;
          dvd  <= {dvd[62:0], 1'b0};
          step <= step - 6'd1;
          if (step == 6'd0) begin
            if (phase == E_DIV_MEAN) begin
              mean  <= mean_next;
              dvd   <= diff;
              dsr   <= {1'b0, cc};
              rem   <= 34'd0;
              quo   <= 64'd0;
              step  <= DIV_LAST;
              phase <= E_DIV_VAR;
            end else begin
              sv    <= quo_next[31:0];
              sat   <= (quo_next[63:32] != 32'd0);
              srem  <= 20'd0;
              root  <= 16'd0;
              step  <= SQRT_LAST;
              phase <= E_SQRT;
            end
          end
        end
        E_SQRT: begin
          srem <= srem_next;
          root <= root_next;
          sv   <= {sv[29:0], 2'b00};
          step <= step - 6'd1;
          if (step == 6'd0) begin
            std_dev <= (sat || root_next[15]) ? 15'h7FFF : root_next[14:0];
            done    <= 1'b1;
            phase   <= E_IDLE;
          end
        end
        default: phase <= E_IDLE;
      endcase
    end
  end

  assign eng_out.done    = done;
  assign eng_out.mean    = mean;
  assign eng_out.std_dev = std_dev;

endmodule

[src/column_summary_statistics.sv]
// Column summary statistics: count, mean, std deviation, min and max of a stream.
//
// Input stream (s_*): one signed Q8.8 sample per beat in s_tdata, s_tlast on the
// final sample of a column. Samples are taken one per cycle while s_tready is
// high. The sample square is registered one stage ahead of the 33-bit sum and
// 47-bit sum-of-squares accumulators; samples beyond MAX_ROWS in a column are
// ignored, but their tlast still closes the column.
// After a tlast beat s_tready drops while a bit-serial engine finishes the
// column: 3 shift-add products of 32 steps, 2 restoring divisions of 64 steps
// and a 16-step square root, before the result is loaded for m_tvalid.
// Throughput is one sample per cycle inside a column, with a pause in intake after each column.
// Output stream (m_*): one beat per column from an output register. If the
// receiver stalls, the result holds; the next column's result then waits with
// s_tready low until the result register can be loaded.
// Reset (rst, synchronous) clears the accumulators, empties the output
// register and leaves the block ready for a new column.
module column_summary_statistics #(
  parameter int MAX_ROWS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample
  input  logic        s_tlast,   // last_in_column
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // [16:0] count, [32:17] mean, [47:33] std_dev,
                                 // [63:48] minimum, [79:64] maximum
);

  localparam logic [csstat_pkg::COUNT_W-1:0] MAX_COUNT = csstat_pkg::COUNT_W'(MAX_ROWS);

  typedef enum logic [1:0] {ST_ACC, ST_FLUSH, ST_START, ST_RUN} state_t;

  state_t state;

  logic in_beat;
  logic out_free;

  // Square stage
  logic signed [15:0] x_in;
  logic signed [31:0] sq_full;
  logic               p_valid;
  logic signed [15:0] p_sample;
  logic [30:0]        p_square;

  // Accumulators
  logic [csstat_pkg::COUNT_W-1:0]        sample_count;
  logic signed [csstat_pkg::SUM_W-1:0]   running_sum;
  logic [csstat_pkg::SUMSQ_W-1:0]        running_sum_squares;
  logic signed [15:0]                    running_min;
  logic signed [15:0]                    running_max;

  // Column result held while the engine runs
  logic [csstat_pkg::COUNT_W-1:0] hold_count;
  logic [15:0]                    hold_min;
  logic [15:0]                    hold_max;

  csstat_pkg::eng_in_t  eng_in;
  csstat_pkg::eng_out_t eng_out;

  assign s_tready = (state == ST_ACC);
  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign x_in     = s_tdata;
  assign sq_full  = x_in * x_in;

  // Square stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= in_beat;
    end
    if (in_beat) begin
      p_sample <= x_in;
      p_square <= sq_full[30:0];
    end
  end

  // Running totals; cleared as the engine takes the column
  always_ff @(posedge clk) begin
    if (rst || state == ST_START) begin
      sample_count        <= '0;
      running_sum         <= '0;
      running_sum_squares <= '0;
      running_min         <= 16'sh7FFF;
      running_max         <= 16'sh8000;
    end else if (p_valid && sample_count < MAX_COUNT) begin
      sample_count        <= sample_count + 1'b1;
      running_sum         <= running_sum + csstat_pkg::SUM_W'(p_sample);
      running_sum_squares <= running_sum_squares + csstat_pkg::SUMSQ_W'(p_square);
      if (p_sample < running_min) running_min <= p_sample;
      if (p_sample > running_max) running_max <= p_sample;
    end
  end

  // Engine request
  assign eng_in.start = (state == ST_START);
  assign eng_in.count = sample_count;
  assign eng_in.sum   = running_sum;
  assign eng_in.sumsq = running_sum_squares;

  csstat_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .eng_in  (eng_in),
    .eng_out (eng_out)
  );

  // Column control and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_ACC;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_ACC: begin
          if (in_beat && s_tlast) state <= ST_FLUSH;
        end
        ST_FLUSH: state <= ST_START;
        ST_START: begin
          hold_count <= sample_count;
          hold_min   <= running_min;
          hold_max   <= running_max;
          state      <= ST_RUN;
        end
        ST_RUN: begin
          if (eng_out.done && out_free) begin
            m_tdata  <= {hold_max, hold_min, eng_out.std_dev, eng_out.mean, hold_count};
            m_tvalid <= 1'b1;
            state    <= ST_ACC;
          end
        end
        default: state <= ST_ACC;
      endcase
    end
  end

endmodule

[src/csstat_checker.sv]
// Port-level checker for the column statistics block, bound to the top level.
`include "assert_macros.svh"

module csstat_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata
);

  // A stalled result beat holds its payload
  `CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

  // Closing a column stops intake while the engine runs
  `CHK_NEXT(a_stop_after_last, s_tvalid && s_tready && s_tlast, !s_tready, "input still ready after column end")

  // Every reported column holds at least one sample
  `CHK_NOW(a_count_nonzero, m_tvalid, m_tdata[16:0] != 17'd0, "result with zero count")

  // Mean lies between minimum and maximum
  `CHK_NOW(a_mean_range, m_tvalid, ($signed(m_tdata[63:48]) <= $signed(m_tdata[32:17])) && ($signed(m_tdata[32:17]) <= $signed(m_tdata[79:64])), "mean outside min..max")

endmodule

bind column_summary_statistics csstat_checker u_csstat_checker (.*);
